>>> hw/rtl/rae_pkg.sv
// ----------------------------------------------------------------------------
// rae_pkg
// Shared types, constants and the arctangent table of the roll angle estimator.
// ----------------------------------------------------------------------------
`default_nettype none

package rae_pkg;

	localparam int FRAC_BITS = 16;
	localparam int DATA_W    = 24;
	localparam int ROLL_W    = 18;
	localparam int THR_W     = 23;
	localparam int NOISE_W   = 32;
	localparam int K_W       = FRAC_BITS + 1;
	localparam int DIV_STEPS = K_W;
	localparam int SQRT_STEPS = FRAC_BITS + 1;
	localparam int CORD_ITERS = FRAC_BITS + 4;
	localparam int ANG_BITS  = 30;
	localparam int CW        = 34;
	localparam int CNT_W     = 5;
	localparam int ADDR_W    = 4;

	localparam logic [19:0] GRAV_Q = 20'd642689;

	localparam logic [ADDR_W-3:0] REG_THR = 2'd0;
	localparam logic [ADDR_W-3:0] REG_PN  = 2'd1;
	localparam logic [ADDR_W-3:0] REG_ON  = 2'd2;

	typedef struct packed {
		logic signed [DATA_W-1:0] lateral_accel;
		logic signed [DATA_W-1:0] speed;
		logic signed [DATA_W-1:0] yaw_rate_raw;
		logic signed [DATA_W-1:0] yaw_offset_moving;
		logic signed [DATA_W-1:0] yaw_offset_stopped;
	} in_t;

	typedef struct packed {
		logic signed [ROLL_W-1:0] roll_angle;
		logic                     enabled;
		logic                     estimating;
	} out_t;

	typedef struct packed {
		logic [THR_W-1:0]   stop_speed_threshold;
		logic [NOISE_W-1:0] process_noise;
		logic [NOISE_W-1:0] observation_noise;
	} cfg_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_PRED, ST_KLOAD, ST_KDIV, ST_KSEL, ST_MUL, ST_UPD, ST_NUM,
		ST_CHK, ST_MDIV, ST_MSEL, ST_MSQ, ST_SQRT, ST_CINIT, ST_CORD, ST_DONE
	} state_t;

	typedef struct packed {
		logic             load;
		logic             pred;
		logic             kload;
		logic             div_step;
		logic             ksel;
		logic             mul;
		logic             upd;
		logic             num;
		logic             chk;
		logic             msel;
		logic             msq;
		logic             sqrt_step;
		logic             cinit;
		logic             cord_step;
		logic             done;
		logic [CNT_W-1:0] idx;
	} cmd_t;

	typedef struct packed {
		logic in_range;
		logic out_free;
	} sts_t;

	function automatic logic signed [CW-1:0] atan_f(input logic [CNT_W-1:0] i);
		logic signed [CW-1:0] v;
		case (i)
			5'd0: v = 34'sd843314857;
			5'd1: v = 34'sd497837829;
			5'd2: v = 34'sd263043837;
			5'd3: v = 34'sd133525159;
			5'd4: v = 34'sd67021687;
			5'd5: v = 34'sd33543516;
			5'd6: v = 34'sd16775851;
			5'd7: v = 34'sd8388437;
			5'd8: v = 34'sd4194283;
			5'd9: v = 34'sd2097149;
			default: v = CW'(34'sd1 <<< (5'd30 - i));
		endcase
		return v;
	endfunction

endpackage

`default_nettype wire

>>> hw/rtl/roll_angle_estimator.sv
// ----------------------------------------------------------------------------
// roll_angle_estimator
// Roll angle from lateral acceleration, speed and yaw rate: scalar Kalman
// smoothing, range test against gravity, arcsine by square root and CORDIC.
// ----------------------------------------------------------------------------
//  channel  | handshake          | payload
//  in       | in_valid/in_stall  | in_data  (rae_pkg::in_t)
//  out      | out_valid/out_stall| out_data (rae_pkg::out_t)
//  cfg      | APB psel/penable   | paddr, pwdata, prdata
//
// The 17-step shared divider serves the Kalman gain and, in range only, the
// arcsine ratio; the 17-step square root and 20-iteration CORDIC run in range.
// in_stall is high from acceptance until the result enters the output register.
// A finished result waits in the output register while out_stall is high.
// Reset restores register defaults and resets filter and estimate state.
// ----------------------------------------------------------------------------
`default_nettype none

module roll_angle_estimator (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         in_valid,
	output logic                        in_stall,
	input  rae_pkg::in_t                in_data,
	output logic                        out_valid,
	input  wire                         out_stall,
	output rae_pkg::out_t               out_data,
	input  wire                         psel,
	input  wire                         penable,
	input  wire                         pwrite,
	input  wire  [rae_pkg::ADDR_W-1:0]  paddr,
	input  wire  [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);
	import rae_pkg::*;

	cfg_t cfg;
	cmd_t cmd;
	sts_t sts;

	assign pready = 1'b1;

	rae_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	rae_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	rae_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_data   (in_data),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule

`default_nettype wire

>>> hw/rtl/rae_cfg.sv
// ----------------------------------------------------------------------------
// rae_cfg
// APB register file: speed threshold and the two filter noise terms.
// ----------------------------------------------------------------------------
`default_nettype none

module rae_cfg (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         psel,
	input  wire                         penable,
	input  wire                         pwrite,
	input  wire  [rae_pkg::ADDR_W-1:0]  paddr,
	input  wire  [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output rae_pkg::cfg_t               cfg
);
	import rae_pkg::*;

	cfg_t cfg_q;
	logic wr;

	assign wr = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.stop_speed_threshold <= THR_W'(655);
			cfg_q.process_noise        <= NOISE_W'(66);
			cfg_q.observation_noise    <= NOISE_W'(655);
		end else if (wr) begin
			unique case (paddr[ADDR_W-1:2])
				REG_THR: cfg_q.stop_speed_threshold <= pwdata[THR_W-1:0];
				REG_PN:  cfg_q.process_noise        <= pwdata;
				REG_ON:  cfg_q.observation_noise    <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[ADDR_W-1:2])
			REG_THR: prdata = 32'(cfg_q.stop_speed_threshold);
			REG_PN:  prdata = cfg_q.process_noise;
			REG_ON:  prdata = cfg_q.observation_noise;
			default: prdata = '0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

>>> hw/rtl/rae_ctrl.sv
// ----------------------------------------------------------------------------
// rae_ctrl
// Sequencer: steps one beat through filter, divider, square root and CORDIC.
// ----------------------------------------------------------------------------
`default_nettype none

module rae_ctrl (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            in_valid,
	output logic           in_stall,
	input  rae_pkg::sts_t  sts,
	output rae_pkg::cmd_t  cmd
);
	import rae_pkg::*;

	state_t state_q, state_d;
	logic [CNT_W-1:0] cnt_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (in_valid) state_d = ST_PRED;
			ST_PRED:  state_d = ST_KLOAD;
			ST_KLOAD: state_d = ST_KDIV;
			ST_KDIV:  if (cnt_q == CNT_W'(DIV_STEPS - 1)) state_d = ST_KSEL;
			ST_KSEL:  state_d = ST_MUL;
			ST_MUL:   state_d = ST_UPD;
			ST_UPD:   state_d = ST_NUM;
			ST_NUM:   state_d = ST_CHK;
			ST_CHK:   state_d = sts.in_range ? ST_MDIV : ST_DONE;
			ST_MDIV:  if (cnt_q == CNT_W'(DIV_STEPS - 1)) state_d = ST_MSEL;
			ST_MSEL:  state_d = ST_MSQ;
			ST_MSQ:   state_d = ST_SQRT;
			ST_SQRT:  if (cnt_q == CNT_W'(SQRT_STEPS - 1)) state_d = ST_CINIT;
			ST_CINIT: state_d = ST_CORD;
			ST_CORD:  if (cnt_q == CNT_W'(CORD_ITERS - 1)) state_d = ST_DONE;
			ST_DONE:  if (sts.out_free) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= (state_d != state_q) ? '0 : cnt_q + 1'b1;
		end
	end

	always_comb begin
		cmd           = '0;
		cmd.idx       = cnt_q;
		cmd.load      = (state_q == ST_IDLE) & in_valid;
		cmd.pred      = (state_q == ST_PRED);
		cmd.kload     = (state_q == ST_KLOAD);
		cmd.div_step  = (state_q == ST_KDIV) | (state_q == ST_MDIV);
		cmd.ksel      = (state_q == ST_KSEL);
		cmd.mul       = (state_q == ST_MUL);
		cmd.upd       = (state_q == ST_UPD);
		cmd.num       = (state_q == ST_NUM);
		cmd.chk       = (state_q == ST_CHK);
		cmd.msel      = (state_q == ST_MSEL);
		cmd.msq       = (state_q == ST_MSQ);
		cmd.sqrt_step = (state_q == ST_SQRT);
		cmd.cinit     = (state_q == ST_CINIT);
		cmd.cord_step = (state_q == ST_CORD);
		cmd.done      = (state_q == ST_DONE) & sts.out_free;
		in_stall      = (state_q != ST_IDLE);
	end

endmodule

`default_nettype wire

>>> hw/rtl/rae_dp.sv
// ----------------------------------------------------------------------------
// rae_dp
// Datapath: Kalman update, restoring divider, integer square root, CORDIC
// arctangent and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module rae_dp (
	input  wire            clk,
	input  wire            arst_n,
	input  rae_pkg::cfg_t  cfg,
	input  rae_pkg::in_t   in_data,
	input  rae_pkg::cmd_t  cmd,
	output rae_pkg::sts_t  sts,
	output logic           out_valid,
	input  wire            out_stall,
	output rae_pkg::out_t  out_data
);
	import rae_pkg::*;

	localparam logic [49:0] LIM = 50'(GRAV_Q) << FRAC_BITS;

	// filter state
	logic signed [DATA_W-1:0] filt_q;
	logic [31:0]              var_q;
	logic                     primed_q;
	logic signed [ROLL_W-1:0] last_roll_q;
	logic                     est_q;

	// per-beat working registers
	in_t                      in_q;
	logic signed [DATA_W:0]   yaw_q;
	logic [31:0]              p_q;
	logic [32:0]              den_q;
	logic [K_W-1:0]           k_q;
	logic signed [42:0]       kprod_q;
	logic [48:0]              vprod_q;
	logic signed [48:0]       sy_q;
	logic signed [49:0]       n_q;
	logic                     neg_q;
	logic                     rng_q;
	logic [32:0]              rem_q;
	logic [K_W-1:0]           lo_q;
	logic [32:0]              dden_q;
	logic [K_W-1:0]           quot_q;
	logic [FRAC_BITS-1:0]     m_q;
	logic [32:0]              sv_q;
	logic [33:0]              r_q;
	logic signed [CW-1:0]     x_q, y_q, z_q;
	out_t                     out_q;
	logic                     out_valid_q;

	logic [DATA_W-1:0]        spd_mag;
	logic signed [DATA_W:0]   yaw;
	logic [32:0]              psum;
	logic [31:0]              p;
	logic signed [DATA_W:0]   diff;
	logic [49:0]              mag;
	logic                     rng;
	logic [33:0]              rs;
	logic                     ge;
	logic [34:0]              sb, st;
	logic                     sge;
	logic signed [CW-1:0]     xs, ys, zr;
	logic signed [ROLL_W-1:0] a, roll;

	assign spd_mag = in_q.speed[DATA_W-1] ? DATA_W'(-in_q.speed) : DATA_W'(in_q.speed);
	assign yaw = (DATA_W+1)'(in_q.yaw_rate_raw) + ((spd_mag > DATA_W'(cfg.stop_speed_threshold))
		? (DATA_W+1)'(in_q.yaw_offset_moving) : (DATA_W+1)'(in_q.yaw_offset_stopped));
	assign psum = 33'(var_q) + 33'(cfg.process_noise);
	assign p    = psum[32] ? 32'hFFFF_FFFF : psum[31:0];
	assign diff = (DATA_W+1)'(in_q.lateral_accel) - (DATA_W+1)'(filt_q);
	assign mag  = n_q[49] ? 50'(-n_q) : 50'(n_q);
	assign rng  = mag < LIM;

	assign rs = {rem_q, lo_q[K_W-1]};
	assign ge = rs >= {1'b0, dden_q};

	assign sb  = 35'(1) << (6'd32 - {cmd.idx, 1'b0});
	assign st  = 35'(r_q) + sb;
	assign sge = 35'(sv_q) >= st;

	assign xs = x_q >>> cmd.idx;
	assign ys = y_q >>> cmd.idx;
	assign zr = z_q + (CW'(1) <<< (ANG_BITS - FRAC_BITS - 1));
	assign a  = ROLL_W'(zr >>> (ANG_BITS - FRAC_BITS));

	always_comb begin
		if (rng_q) roll = neg_q ? -a : a;
		else if (est_q) roll = last_roll_q;
		else roll = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filt_q      <= '0;
			var_q       <= 32'(1) << FRAC_BITS;
			primed_q    <= 1'b0;
			last_roll_q <= '0;
			est_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load && !primed_q) begin
				filt_q   <= in_data.lateral_accel;
				var_q    <= 32'(1) << FRAC_BITS;
				primed_q <= 1'b1;
			end
			if (cmd.upd) begin
				filt_q <= filt_q + DATA_W'(kprod_q >>> FRAC_BITS);
			end
			if (cmd.num) begin
				var_q  <= vprod_q[FRAC_BITS +: 32];
			end
			if (cmd.done) begin
				last_roll_q <= roll;
				est_q       <= est_q | rng_q;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) in_q <= in_data;
		if (cmd.pred) begin
			yaw_q <= yaw;
			p_q   <= p;
			den_q <= 33'(p) + 33'(cfg.observation_noise);
		end
		if (cmd.kload) begin
			rem_q  <= 33'(p_q >> 1);
			lo_q   <= {p_q[0], {FRAC_BITS{1'b0}}};
			dden_q <= den_q;
		end
		if (cmd.chk) begin
			rng_q  <= rng;
			neg_q  <= n_q[49];
			rem_q  <= 33'(mag >> K_W);
			lo_q   <= mag[K_W-1:0];
			dden_q <= 33'(GRAV_Q);
		end
		if (cmd.div_step) begin
			rem_q  <= ge ? 33'(rs - {1'b0, dden_q}) : 33'(rs);
			quot_q <= {quot_q[K_W-2:0], ge};
			lo_q   <= lo_q << 1;
		end
		if (cmd.ksel) k_q <= (den_q == '0) ? '0 : quot_q;
		if (cmd.mul) begin
			kprod_q <= 43'($signed({1'b0, k_q})) * 43'(diff);
			vprod_q <= 49'(K_W'(1) << FRAC_BITS) - 49'(k_q);
			sy_q    <= 49'(in_q.speed) * 49'(yaw_q);
		end
		if (cmd.upd) vprod_q <= 49'(vprod_q[K_W-1:0]) * 49'(p_q);
		if (cmd.num) n_q <= 50'(sy_q) - (50'(filt_q) <<< FRAC_BITS);
		if (cmd.msel) m_q <= quot_q[FRAC_BITS-1:0];
		if (cmd.msq) begin
			sv_q <= (33'(1) << (2 * FRAC_BITS)) - 33'(m_q) * 33'(m_q);
			r_q  <= '0;
		end
		if (cmd.sqrt_step) begin
			if (sge) begin
				sv_q <= 33'(35'(sv_q) - st);
				r_q  <= (r_q >> 1) + 34'(sb);
			end else begin
				r_q  <= r_q >> 1;
			end
		end
		if (cmd.cinit) begin
			x_q <= CW'(r_q[FRAC_BITS:0]) <<< (ANG_BITS - FRAC_BITS);
			y_q <= CW'(m_q) <<< (ANG_BITS - FRAC_BITS);
			z_q <= '0;
		end
		if (cmd.cord_step) begin
			if (!y_q[CW-1]) begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + atan_f(cmd.idx);
			end else begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - atan_f(cmd.idx);
			end
		end
		if (cmd.done) begin
			out_q.roll_angle <= roll;
			out_q.enabled    <= rng_q;
			out_q.estimating <= est_q | rng_q;
		end
	end

	assign sts.in_range = rng;
	assign sts.out_free = !out_valid_q || !out_stall;
	assign out_valid    = out_valid_q;
	assign out_data     = out_q;

endmodule

`default_nettype wire
